@@ hw/rtl/pat_pkg.sv @@
package pat_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int FIELD_W    = 32;
    localparam int DIFF_W     = FIELD_W + 1;
    localparam int TRIG_W     = 18;
    localparam int OP_W       = 3;
    localparam int REG_IDX_W  = 3;
    localparam int Q_FRAC     = 16;
    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);
    localparam int ATAN_W     = 31;

    typedef enum logic [OP_W-1:0] {
        OP_TRANSLATE = 3'd0,
        OP_ROT_X     = 3'd1,
        OP_ROT_Y     = 3'd2,
        OP_ROT_Z     = 3'd3,
        OP_SCALE     = 3'd4
    } op_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_OPERATION = 3'd0,
        REG_PARAM_A   = 3'd1,
        REG_PARAM_B   = 3'd2,
        REG_PARAM_C   = 3'd3,
        REG_PIVOT_X   = 3'd4,
        REG_PIVOT_Y   = 3'd5,
        REG_PIVOT_Z   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        op_t                       op;
        logic signed [FIELD_W-1:0] param_a;
        logic signed [FIELD_W-1:0] param_b;
        logic signed [FIELD_W-1:0] param_c;
        logic signed [FIELD_W-1:0] pivot_x;
        logic signed [FIELD_W-1:0] pivot_y;
        logic signed [FIELD_W-1:0] pivot_z;
    } cfg_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sine;
        logic signed [TRIG_W-1:0] cosine;
    } trig_t;

    // Arctangent of 2^-i in Q2.30, rounded.
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 31'd843314857;
            5'd1:    val = 31'd497837830;
            5'd2:    val = 31'd263043837;
            5'd3:    val = 31'd133525159;
            5'd4:    val = 31'd67021687;
            5'd5:    val = 31'd33543516;
            5'd6:    val = 31'd16775851;
            5'd7:    val = 31'd8388437;
            5'd8:    val = 31'd4194283;
            5'd9:    val = 31'd2097149;
            5'd10:   val = 31'd1048576;
            5'd11:   val = 31'd524288;
            5'd12:   val = 31'd262144;
            5'd13:   val = 31'd131072;
            5'd14:   val = 31'd65536;
            5'd15:   val = 31'd32768;
            5'd16:   val = 31'd16384;
            5'd17:   val = 31'd8192;
            5'd18:   val = 31'd4096;
            5'd19:   val = 31'd2048;
            5'd20:   val = 31'd1024;
            5'd21:   val = 31'd512;
            5'd22:   val = 31'd256;
            5'd23:   val = 31'd128;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ hw/rtl/pat_point_if.sv @@
interface pat_point_if import pat_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] in_x;
    logic signed [FIELD_W-1:0] in_y;
    logic signed [FIELD_W-1:0] in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

@@ hw/rtl/pat_result_if.sv @@
interface pat_result_if import pat_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic                      overflow;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output overflow, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input overflow, output ready);
endinterface

@@ hw/rtl/pat_cfg_if.sv @@
interface pat_cfg_if import pat_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [FIELD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/pat_cordic.sv @@
module pat_cordic import pat_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [FIELD_W-1:0] angle,
    output logic                      busy,
    output trig_t                     trig
);

    localparam int XY_W        = 34;
    localparam int Z_W         = 35;
    localparam int ANGLE_SHIFT = 14;
    localparam int TRIG_SHIFT  = 14;
    localparam int STEP_W      = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    localparam logic signed [FIELD_W-1:0] PI_Q16      = 32'sd205887;
    localparam logic signed [Z_W-1:0]     PI_Q30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0]     HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [XY_W-1:0]    GAIN_Q30    = 34'sd652032874;
    localparam logic signed [XY_W-1:0]    TRIG_MAX    = 34'sd131071;
    localparam logic signed [XY_W-1:0]    TRIG_MIN    = -34'sd131072;
    localparam logic signed [XY_W-1:0]    TRIG_HALF   = XY_W'(1) <<< (TRIG_SHIFT - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic                     flip_reg, flip_next;
    logic signed [TRIG_W-1:0] sine_reg, sine_next;
    logic signed [TRIG_W-1:0] cosine_reg, cosine_next;

    logic signed [FIELD_W-1:0] ang_c;
    logic signed [Z_W-1:0]     z_start;
    logic signed [XY_W-1:0]    x_sh, y_sh;
    logic signed [Z_W-1:0]     atan_step;
    logic signed [XY_W-1:0]    x_rnd, y_rnd;

    always_comb
    begin
        if (angle > PI_Q16)
            ang_c = PI_Q16;
        else if (angle < -PI_Q16)
            ang_c = -PI_Q16;
        else
            ang_c = angle;
        z_start = Z_W'(ang_c) <<< ANGLE_SHIFT;

        x_sh      = x_reg >>> step_reg;
        y_sh      = y_reg >>> step_reg;
        atan_step = signed'(Z_W'(atan_q30(ATAN_IDX_W'(step_reg))));

        x_rnd = (x_reg + TRIG_HALF) >>> TRIG_SHIFT;
        y_rnd = (y_reg + TRIG_HALF) >>> TRIG_SHIFT;
        if (flip_reg)
        begin
            x_rnd = -x_rnd;
            y_rnd = -y_rnd;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        flip_next   = flip_reg;
        sine_next   = sine_reg;
        cosine_next = cosine_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                    x_next     = GAIN_Q30;
                    y_next     = '0;
                    // Angles beyond a quarter turn are folded by pi and the result negated.
                    if (z_start > HALF_PI_Q30)
                    begin
                        z_next    = z_start - PI_Q30;
                        flip_next = 1'b1;
                    end
                    else if (z_start < -HALF_PI_Q30)
                    begin
                        z_next    = z_start + PI_Q30;
                        flip_next = 1'b1;
                    end
                    else
                    begin
                        z_next    = z_start;
                        flip_next = 1'b0;
                    end
                end
            end
            ST_RUN:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_step;
                end
                else
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_step;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (x_rnd > TRIG_MAX)
                    cosine_next = TRIG_MAX[TRIG_W-1:0];
                else if (x_rnd < TRIG_MIN)
                    cosine_next = TRIG_MIN[TRIG_W-1:0];
                else
                    cosine_next = x_rnd[TRIG_W-1:0];
                if (y_rnd > TRIG_MAX)
                    sine_next = TRIG_MAX[TRIG_W-1:0];
                else if (y_rnd < TRIG_MIN)
                    sine_next = TRIG_MIN[TRIG_W-1:0];
                else
                    sine_next = y_rnd[TRIG_W-1:0];
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            sine_reg   <= '0;
            cosine_reg <= 18'sd65536;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign trig.sine   = sine_reg;
    assign trig.cosine = cosine_reg;

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start && state_reg == ST_IDLE |=> state_reg == ST_RUN)
        else $error("cordic did not start");

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && step_reg == STEP_LAST |=> state_reg == ST_DONE)
        else $error("cordic ran past its last step");

    a_trig_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_DONE |=> $stable(sine_reg) && $stable(cosine_reg))
        else $error("sine or cosine changed outside the update cycle");

endmodule

@@ hw/rtl/pat_datapath.sv @@
module pat_datapath import pat_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hold,
    input  cfg_t          cfg_regs,
    input  trig_t         trig,
    pat_point_if.sink     point,
    pat_result_if.source  result
);

    localparam int ROT_W = DIFF_W + TRIG_W;
    localparam int SCL_W = DIFF_W + FIELD_W;
    localparam int R_W   = SCL_W + 3;

    localparam logic signed [R_W-1:0] SAT_HI =
        signed'({{(R_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}});
    localparam logic signed [R_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [R_W-1:0] ROUND_HALF =
        signed'({{(R_W - Q_FRAC){1'b0}}, 1'b1, {(Q_FRAC - 1){1'b0}}});

    logic rdy0, rdy1, rdy2, acc0;
    logic v0_reg, v1_reg, v2_reg;

    logic signed [FIELD_W-1:0] in_p   [3];
    logic signed [FIELD_W-1:0] pivot  [3];
    logic signed [FIELD_W-1:0] prm    [3];

    logic signed [FIELD_W-1:0] p0_reg [3];
    logic signed [DIFF_W-1:0]  d0_reg [3];

    logic signed [DIFF_W-1:0]  u_op, v_op;
    logic signed [ROT_W-1:0]   uc, vs, us, vc;
    logic signed [SCL_W-1:0]   k    [3];

    logic signed [FIELD_W-1:0] p1_reg [3];
    logic signed [ROT_W-1:0]   uc1_reg, vs1_reg, us1_reg, vc1_reg;
    logic signed [SCL_W-1:0]   k1_reg [3];

    logic signed [R_W-1:0]     rot_a, rot_b;
    logic signed [R_W-1:0]     r    [3];
    logic signed [R_W-1:0]     sat  [3];
    logic                      ovf;

    logic signed [FIELD_W-1:0] ox_reg, oy_reg, oz_reg;
    logic                      ovf_reg;

    function automatic logic signed [R_W-1:0] round_q16(input logic signed [R_W-1:0] v);
        return (v + ROUND_HALF) >>> Q_FRAC;
    endfunction

    assign rdy2 = !v2_reg || result.ready;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign point.ready = rdy0 && !hold;
    assign acc0 = point.valid && point.ready;

    always_comb
    begin
        in_p[0]  = point.in_x;
        in_p[1]  = point.in_y;
        in_p[2]  = point.in_z;
        pivot[0] = cfg_regs.pivot_x;
        pivot[1] = cfg_regs.pivot_y;
        pivot[2] = cfg_regs.pivot_z;
        prm[0]   = cfg_regs.param_a;
        prm[1]   = cfg_regs.param_b;
        prm[2]   = cfg_regs.param_c;
    end

    // Stage 1 operands: the two coordinates that the rotation mixes.
    always_comb
    begin
        case (cfg_regs.op)
            OP_ROT_X:
            begin
                u_op = d0_reg[1];
                v_op = d0_reg[2];
            end
            OP_ROT_Y:
            begin
                u_op = d0_reg[0];
                v_op = d0_reg[2];
            end
            default:
            begin
                u_op = d0_reg[0];
                v_op = d0_reg[1];
            end
        endcase
        uc = u_op * trig.cosine;
        vs = v_op * trig.sine;
        us = u_op * trig.sine;
        vc = v_op * trig.cosine;
        for (int i = 0; i < 3; i++)
            k[i] = d0_reg[i] * prm[i];
    end

    always_comb
    begin
        rot_a = round_q16(R_W'(uc1_reg) - R_W'(vs1_reg));
        rot_b = round_q16(R_W'(us1_reg) + R_W'(vc1_reg));
        for (int i = 0; i < 3; i++)
            r[i] = R_W'(p1_reg[i]);
        case (cfg_regs.op)
            OP_TRANSLATE:
            begin
                for (int i = 0; i < 3; i++)
                    r[i] = R_W'(p1_reg[i]) + R_W'(prm[i]);
            end
            OP_ROT_X:
            begin
                r[1] = rot_a + R_W'(pivot[1]);
                r[2] = rot_b + R_W'(pivot[2]);
            end
            OP_ROT_Y:
            begin
                r[0] = rot_a + R_W'(pivot[0]);
                r[2] = rot_b + R_W'(pivot[2]);
            end
            OP_ROT_Z:
            begin
                r[0] = rot_a + R_W'(pivot[0]);
                r[1] = rot_b + R_W'(pivot[1]);
            end
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                    r[i] = round_q16(R_W'(k1_reg[i])) + R_W'(pivot[i]);
            end
            default:
            begin
            end
        endcase

        ovf = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (r[i] > SAT_HI)
            begin
                sat[i] = SAT_HI;
                ovf    = 1'b1;
            end
            else if (r[i] < SAT_LO)
            begin
                sat[i] = SAT_LO;
                ovf    = 1'b1;
            end
            else
            begin
                sat[i] = r[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= acc0;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p0_reg[i] <= in_p[i];
                d0_reg[i] <= DIFF_W'(in_p[i]) - DIFF_W'(pivot[i]);
            end
        end
        if (rdy1 && v0_reg)
        begin
            uc1_reg <= uc;
            vs1_reg <= vs;
            us1_reg <= us;
            vc1_reg <= vc;
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= p0_reg[i];
                k1_reg[i] <= k[i];
            end
        end
        if (rdy2 && v1_reg)
        begin
            ox_reg  <= sat[0][FIELD_W-1:0];
            oy_reg  <= sat[1][FIELD_W-1:0];
            oz_reg  <= sat[2][FIELD_W-1:0];
            ovf_reg <= ovf;
        end
    end

    assign result.valid    = v2_reg;
    assign result.out_x    = ox_reg;
    assign result.out_y    = oy_reg;
    assign result.out_z    = oz_reg;
    assign result.overflow = ovf_reg;

    a_stage1_held: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !rdy2 |=> v1_reg)
        else $error("item in the product stage was dropped during a stall");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && result.ready && !v1_reg |=> !v2_reg)
        else $error("result item repeated after it was taken");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !result.ready |=> v2_reg && $stable(ox_reg) && $stable(oy_reg)
            && $stable(oz_reg) && $stable(ovf_reg))
        else $error("result item changed while it waited");

endmodule

@@ hw/rtl/point3d_affine_transform_unit.sv @@
// Affine transform of a stream of 3D points in signed Q16.16.
//
// Channels: point carries in_x, in_y, in_z and result carries out_x, out_y,
// out_z and overflow; both move an item on a cycle where valid and ready
// are high. The cfg channel writes one register per handshake: index 0
// selects the operation, 1 to 3 hold the parameters, 4 to 6 the pivot.
// Writes to index 7 are taken and ignored.
//
// Throughput is one item per cycle when the receiver keeps up and the
// sine and cosine unit is idle. An item passes an input register, a
// product register and the result register, in that order. When the
// receiver stalls, the three registers fill and then point.ready drops;
// up to three items wait inside.
// A write of param_a starts the sine and cosine unit, which iterates one
// step per cycle and holds point.ready and cfg.ready low until it has
// updated the sine and cosine. Reset clears the configuration registers,
// sets the sine to zero and the cosine to one, and empties the pipeline.
module point3d_affine_transform_unit import pat_pkg::*; #(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pat_cfg_if.sink      cfg,
    pat_point_if.sink    point,
    pat_result_if.source result
);

    cfg_t  cfg_reg, cfg_next;
    trig_t trig;
    logic  busy;
    logic  cfg_wr;
    logic  trig_start;

    assign cfg.ready  = !busy;
    assign cfg_wr     = cfg.valid && cfg.ready;
    assign trig_start = cfg_wr && (cfg.index == REG_PARAM_A);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx_t'(cfg.index))
                REG_OPERATION: cfg_next.op      = op_t'(cfg.data[OP_W-1:0]);
                REG_PARAM_A:   cfg_next.param_a = signed'(cfg.data);
                REG_PARAM_B:   cfg_next.param_b = signed'(cfg.data);
                REG_PARAM_C:   cfg_next.param_c = signed'(cfg.data);
                REG_PIVOT_X:   cfg_next.pivot_x = signed'(cfg.data);
                REG_PIVOT_Y:   cfg_next.pivot_y = signed'(cfg.data);
                REG_PIVOT_Z:   cfg_next.pivot_z = signed'(cfg.data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    pat_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .angle (signed'(cfg.data)),
        .busy  (busy),
        .trig  (trig)
    );

    pat_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (busy),
        .cfg_regs (cfg_reg),
        .trig     (trig),
        .point    (point),
        .result   (result)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench import pat_pkg::*; ();

    localparam int     CLK_PERIOD  = 10;
    localparam int     RESET_TICKS = 10;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     LONG_HOLD   = 300;
    localparam int     TAIL_TICKS  = 20;
    localparam int     MAX_REPORTS = 10;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [FIELD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FIELD_W-1:0] Q_MIN = 32'sh8000_0000;

    localparam longint ANGLE_LIMIT = 205887;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam longint TRIG_HI     = 131071;
    localparam longint TRIG_LO     = -131072;
    localparam longint COORD_MAX   = (longint'(1) << (COORD_WIDTH_DEF - 1)) - 1;
    localparam longint COORD_MIN   = -COORD_MAX - 1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
        logic                      ovf;
    } point_result_t;

    typedef struct packed {
        logic                      is_write;
        logic [REG_IDX_W-1:0]      reg_index;
        logic [FIELD_W-1:0]        reg_data;
        logic signed [FIELD_W-1:0] px;
        logic signed [FIELD_W-1:0] py;
        logic signed [FIELD_W-1:0] pz;
        logic                      known;
        point_result_t             want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    pat_cfg_if    cfg_ch();
    pat_point_if  point_ch();
    pat_result_if result_ch();

    point3d_affine_transform_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .point  (point_ch),
        .result (result_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow copy of the transform registers and the sine and cosine in Q1.16.
    logic [OP_W-1:0]           cur_op;
    logic signed [FIELD_W-1:0] param_a, param_b, param_c;
    logic signed [FIELD_W-1:0] pivot_x, pivot_y, pivot_z;
    longint                    sin_q16, cos_q16;

    point_result_t expected_points [$];
    stim_row_t     directed_rows [$];

    int  error_count;
    int  results_seen;
    int  burst_left;
    int  hold_left;
    int  pattern_left;
    int  pattern_mode;
    int  pattern_tick;
    bit  long_hold_req;
    bit  long_hold_taken;

    function automatic longint arctan_q30(input int idx);
        case (idx)
            0:       return 843314857;
            1:       return 497837830;
            2:       return 263043837;
            3:       return 133525159;
            4:       return 67021687;
            5:       return 33543516;
            6:       return 16775851;
            7:       return 8388437;
            8:       return 4194283;
            9:       return 2097149;
            10:      return 1048576;
            11:      return 524288;
            12:      return 262144;
            13:      return 131072;
            14:      return 65536;
            15:      return 32768;
            16:      return 16384;
            17:      return 8192;
            18:      return 4096;
            19:      return 2048;
            20:      return 1024;
            21:      return 512;
            22:      return 256;
            23:      return 128;
            default: return 0;
        endcase
    endfunction

    function automatic longint clamp_trig(input longint v);
        if (v > TRIG_HI)
            return TRIG_HI;
        if (v < TRIG_LO)
            return TRIG_LO;
        return v;
    endfunction

    function automatic longint round_q16(input longint v);
        return (v + 32768) >>> Q_FRAC;
    endfunction

    // The angle is clamped to pi, folded into the half plane around zero and
    // fed to a rotation-mode CORDIC in Q2.30.
    function automatic void update_sin_cos(input logic signed [FIELD_W-1:0] angle);
        longint ang, resid, cx, cy, nx, ny;
        bit     folded;
        int     step;
        ang = angle;
        if (ang > ANGLE_LIMIT)
            ang = ANGLE_LIMIT;
        else if (ang < -ANGLE_LIMIT)
            ang = -ANGLE_LIMIT;
        resid = ang * 16384;
        folded = 1'b0;
        if (resid > HALF_PI_Q30)
        begin
            resid -= PI_Q30;
            folded = 1'b1;
        end
        else if (resid < -HALF_PI_Q30)
        begin
            resid += PI_Q30;
            folded = 1'b1;
        end
        cx = CORDIC_GAIN;
        cy = 0;
        for (step = 0; step < CORDIC_STEPS_DEF; step++)
        begin
            if (resid >= 0)
            begin
                nx = cx - (cy >>> step);
                ny = cy + (cx >>> step);
                resid -= arctan_q30(step);
            end
            else
            begin
                nx = cx + (cy >>> step);
                ny = cy - (cx >>> step);
                resid += arctan_q30(step);
            end
            cx = nx;
            cy = ny;
        end
        cx = (cx + 8192) >>> 14;
        cy = (cy + 8192) >>> 14;
        if (folded)
        begin
            cx = -cx;
            cy = -cy;
        end
        cos_q16 = clamp_trig(cx);
        sin_q16 = clamp_trig(cy);
    endfunction

    function automatic void apply_config(input logic [REG_IDX_W-1:0] idx,
                                         input logic [FIELD_W-1:0] value);
        case (idx)
            REG_OPERATION: cur_op = value[OP_W-1:0];
            REG_PARAM_A:
            begin
                param_a = value;
                update_sin_cos(value);
            end
            REG_PARAM_B:   param_b = value;
            REG_PARAM_C:   param_c = value;
            REG_PIVOT_X:   pivot_x = value;
            REG_PIVOT_Y:   pivot_y = value;
            REG_PIVOT_Z:   pivot_z = value;
            default:       ;
        endcase
    endfunction

    function automatic point_result_t transform_point(input logic signed [FIELD_W-1:0] px,
                                                      input logic signed [FIELD_W-1:0] py,
                                                      input logic signed [FIELD_W-1:0] pz);
        longint        pos [3];
        longint        piv [3];
        longint        fac [3];
        longint        dif [3];
        longint        res [3];
        point_result_t moved;
        int            axis;
        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        piv[0] = pivot_x;
        piv[1] = pivot_y;
        piv[2] = pivot_z;
        fac[0] = param_a;
        fac[1] = param_b;
        fac[2] = param_c;
        for (axis = 0; axis < 3; axis++)
        begin
            dif[axis] = pos[axis] - piv[axis];
            res[axis] = pos[axis];
        end
        case (cur_op)
            OP_TRANSLATE:
                for (axis = 0; axis < 3; axis++)
                    res[axis] = pos[axis] + fac[axis];
            OP_ROT_X:
            begin
                res[1] = round_q16(dif[1] * cos_q16 - dif[2] * sin_q16) + piv[1];
                res[2] = round_q16(dif[1] * sin_q16 + dif[2] * cos_q16) + piv[2];
            end
            OP_ROT_Y:
            begin
                res[0] = round_q16(dif[0] * cos_q16 - dif[2] * sin_q16) + piv[0];
                res[2] = round_q16(dif[0] * sin_q16 + dif[2] * cos_q16) + piv[2];
            end
            OP_ROT_Z:
            begin
                res[0] = round_q16(dif[0] * cos_q16 - dif[1] * sin_q16) + piv[0];
                res[1] = round_q16(dif[0] * sin_q16 + dif[1] * cos_q16) + piv[1];
            end
            OP_SCALE:
                for (axis = 0; axis < 3; axis++)
                    res[axis] = round_q16(dif[axis] * fac[axis]) + piv[axis];
            default: ;
        endcase
        moved.ovf = 1'b0;
        for (axis = 0; axis < 3; axis++)
        begin
            if (res[axis] > COORD_MAX)
            begin
                res[axis] = COORD_MAX;
                moved.ovf = 1'b1;
            end
            else if (res[axis] < COORD_MIN)
            begin
                res[axis] = COORD_MIN;
                moved.ovf = 1'b1;
            end
        end
        moved.x = 32'(res[0]);
        moved.y = 32'(res[1]);
        moved.z = 32'(res[2]);
        return moved;
    endfunction

    function automatic stim_row_t write_row(input logic [REG_IDX_W-1:0] idx,
                                            input logic [FIELD_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_index = idx;
        row.reg_data = value;
        return row;
    endfunction

    function automatic stim_row_t point_row(input logic signed [FIELD_W-1:0] px,
                                            input logic signed [FIELD_W-1:0] py,
                                            input logic signed [FIELD_W-1:0] pz);
        stim_row_t row;
        row = '0;
        row.px = px;
        row.py = py;
        row.pz = pz;
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic signed [FIELD_W-1:0] px,
                                            input logic signed [FIELD_W-1:0] py,
                                            input logic signed [FIELD_W-1:0] pz,
                                            input logic signed [FIELD_W-1:0] wx,
                                            input logic signed [FIELD_W-1:0] wy,
                                            input logic signed [FIELD_W-1:0] wz,
                                            input logic wovf);
        stim_row_t row;
        row = point_row(px, py, pz);
        row.known = 1'b1;
        row.want = '{x: wx, y: wy, z: wz, ovf: wovf};
        return row;
    endfunction

    function automatic logic signed [FIELD_W-1:0] rand_q16(input int spread);
        case ($urandom_range(0, 19))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3, 4: return $urandom;
            default: return 32'(int'($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_config(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_point(input logic signed [FIELD_W-1:0] px,
                              input logic signed [FIELD_W-1:0] py,
                              input logic signed [FIELD_W-1:0] pz,
                              input point_result_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                point_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        point_ch.valid <= 1'b1;
        point_ch.in_x  <= px;
        point_ch.in_y  <= py;
        point_ch.in_z  <= pz;
        do
            @(posedge clk);
        while (!point_ch.ready);
        expected_points.push_back(want);
    endtask

    task automatic drain_points();
        point_ch.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random_phase(input int n_items, input bit with_hold);
        logic [OP_W-1:0]           op;
        int                        sel;
        int                        spread;
        int                        n;
        logic signed [FIELD_W-1:0] px, py, pz;
        drain_points();
        sel = $urandom_range(0, 19);
        op = (sel < 18) ? OP_W'(sel % 5) : OP_W'($urandom_range(5, 7));
        write_reg(REG_OPERATION, {29'($urandom), op});
        if (op == OP_ROT_X || op == OP_ROT_Y || op == OP_ROT_Z)
            spread = 250000;
        else if (op == OP_SCALE)
            spread = 262144;
        else
            spread = 1 << 24;
        if ($urandom_range(0, 9) < 7)
            write_reg(REG_PARAM_A, rand_q16(spread));
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_PARAM_B, rand_q16(spread));
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_PARAM_C, rand_q16(spread));
        if ($urandom_range(0, 9) < 4)
            write_reg(REG_PIVOT_X, ($urandom_range(0, 3) == 0) ? '0 : rand_q16(1 << 22));
        if ($urandom_range(0, 9) < 4)
            write_reg(REG_PIVOT_Y, ($urandom_range(0, 3) == 0) ? '0 : rand_q16(1 << 22));
        if ($urandom_range(0, 9) < 4)
            write_reg(REG_PIVOT_Z, ($urandom_range(0, 3) == 0) ? '0 : rand_q16(1 << 22));
        if ($urandom_range(0, 9) == 0)
            write_reg(REG_UNUSED, $urandom);
        if (with_hold)
            long_hold_req = 1'b1;
        for (n = 0; n < n_items; n++)
        begin
            px = rand_q16(1 << 22);
            py = rand_q16(1 << 22);
            pz = rand_q16(1 << 22);
            send_point(px, py, pz, transform_point(px, py, pz));
        end
    endtask

    task automatic check_result();
        point_result_t want;
        point_result_t got;
        got = '{x: result_ch.out_x, y: result_ch.out_y, z: result_ch.out_z,
                ovf: result_ch.overflow};
        results_seen++;
        if (expected_points.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("result %0d arrived with nothing expected: x=%0d y=%0d z=%0d ovf=%0b",
                         results_seen, got.x, got.y, got.z, got.ovf);
            return;
        end
        want = expected_points.pop_front();
        if (got !== want)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("result %0d mismatch: expected x=%0d y=%0d z=%0d ovf=%0b,",
                         results_seen, want.x, want.y, want.z, want.ovf,
                         " got x=%0d y=%0d z=%0d ovf=%0b",
                         got.x, got.y, got.z, got.ovf);
        end
    endtask

    // Receiver: checks each accepted item and stalls on a changing pattern,
    // with one long hold-off that lets the pipeline fill up.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result();
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (long_hold_req && !long_hold_taken)
            begin
                long_hold_taken = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_mode = $urandom_range(0, 3);
                    pattern_left = $urandom_range(16, 200);
                end
                else
                    pattern_left--;
                pattern_tick++;
                case (pattern_mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 9) < 7);
                    2:       result_ch.ready <= ($urandom_range(0, 9) < 3);
                    default: result_ch.ready <= (pattern_tick % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("point3d_affine_transform_unit test failed");
        $finish;
    end

    initial
    begin
        int row_no;
        int phase;
        stim_row_t row;

        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        point_ch.valid = 1'b0;
        point_ch.in_x = '0;
        point_ch.in_y = '0;
        point_ch.in_z = '0;

        cur_op = OP_TRANSLATE;
        param_a = '0;
        param_b = '0;
        param_c = '0;
        pivot_x = '0;
        pivot_y = '0;
        pivot_z = '0;
        sin_q16 = 0;
        cos_q16 = 65536;
        error_count = 0;
        results_seen = 0;
        burst_left = 0;
        hold_left = 0;
        pattern_left = 0;
        pattern_mode = 0;
        pattern_tick = 0;
        long_hold_req = 1'b0;
        long_hold_taken = 1'b0;

        // After reset the transform is a translate by zero.
        directed_rows.push_back(known_row(0, 0, 0, 0, 0, 0, 1'b0));
        directed_rows.push_back(known_row(Q_MAX, Q_MIN, -1, Q_MAX, Q_MIN, -1, 1'b0));
        // Extreme offsets saturate every axis; the angle write clamps to pi.
        directed_rows.push_back(write_row(REG_PARAM_A, Q_MAX));
        directed_rows.push_back(write_row(REG_PARAM_B, Q_MIN));
        directed_rows.push_back(write_row(REG_PARAM_C, 32'sd1));
        directed_rows.push_back(known_row(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, 1'b1));
        directed_rows.push_back(known_row(Q_MIN, Q_MAX, 0, -1, -1, 1, 1'b0));
        // The pivot has no effect on a translate.
        directed_rows.push_back(write_row(REG_PIVOT_X, 32'h1234_5678));
        directed_rows.push_back(known_row(0, 0, 0, Q_MAX, Q_MIN, 1, 1'b0));
        directed_rows.push_back(write_row(REG_OPERATION, 32'(OP_ROT_X)));
        directed_rows.push_back(point_row(65536, 131072, -196608));
        directed_rows.push_back(point_row(Q_MAX, Q_MIN, Q_MAX));
        directed_rows.push_back(write_row(REG_OPERATION, 32'(OP_ROT_Y)));
        directed_rows.push_back(point_row(Q_MIN, 5, Q_MAX));
        directed_rows.push_back(write_row(REG_PARAM_A, Q_MIN));
        directed_rows.push_back(write_row(REG_PIVOT_Y, Q_MIN));
        directed_rows.push_back(write_row(REG_PIVOT_Z, Q_MAX));
        directed_rows.push_back(write_row(REG_OPERATION, 32'(OP_ROT_Z)));
        directed_rows.push_back(point_row(Q_MAX, Q_MAX, 0));
        directed_rows.push_back(point_row(Q_MIN, 65536, 7));
        // A zero angle still goes through the CORDIC.
        directed_rows.push_back(write_row(REG_PARAM_A, 0));
        directed_rows.push_back(point_row(123456, -654321, 1));
        // Angles on either side of the fold at pi/2.
        directed_rows.push_back(write_row(REG_PARAM_A, 102944));
        directed_rows.push_back(write_row(REG_OPERATION, 32'(OP_ROT_X)));
        directed_rows.push_back(point_row(65536, 65536, 65536));
        directed_rows.push_back(write_row(REG_PARAM_A, 102943));
        directed_rows.push_back(point_row(65536, 65536, 65536));
        directed_rows.push_back(write_row(REG_OPERATION, 32'(OP_SCALE)));
        directed_rows.push_back(write_row(REG_PARAM_C, 0));
        directed_rows.push_back(point_row(Q_MIN, Q_MAX, Q_MAX));
        directed_rows.push_back(point_row(Q_MAX, Q_MIN, Q_MIN));
        // Undefined operations pass the point through; only the low bits select.
        directed_rows.push_back(write_row(REG_OPERATION, 32'hFFFF_FFFD));
        directed_rows.push_back(known_row(Q_MAX, Q_MIN, 42, Q_MAX, Q_MIN, 42, 1'b0));
        directed_rows.push_back(write_row(REG_OPERATION, 32'd6));
        directed_rows.push_back(known_row(Q_MIN, -3, Q_MAX, Q_MIN, -3, Q_MAX, 1'b0));
        directed_rows.push_back(write_row(REG_OPERATION, 32'd7));
        directed_rows.push_back(known_row(-1, 0, Q_MIN, -1, 0, Q_MIN, 1'b0));
        // A write to the unused index changes nothing.
        directed_rows.push_back(write_row(REG_UNUSED, 32'hFFFF_FFFF));
        directed_rows.push_back(known_row(17, Q_MAX, -17, 17, Q_MAX, -17, 1'b0));

        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row_no = 0; row_no < directed_rows.size(); row_no++)
        begin
            row = directed_rows[row_no];
            if (row.is_write)
            begin
                drain_points();
                write_reg(row.reg_index, row.reg_data);
            end
            else if (row.known)
                send_point(row.px, row.py, row.pz, row.want);
            else
                send_point(row.px, row.py, row.pz, transform_point(row.px, row.py, row.pz));
        end

        for (phase = 0; phase < 30; phase++)
            run_random_phase($urandom_range(30, 66), phase == 4);

        drain_points();
        repeat (TAIL_TICKS) @(posedge clk);
        if (error_count == 0 && expected_points.size() == 0)
            $display("point3d_affine_transform_unit test passed");
        else
            $display("point3d_affine_transform_unit test failed");
        $finish;
    end

endmodule
